// ----- src/mssc_pkg.sv -----
// ----------------------------------------------------------------------------
// mssc_pkg
// Shared constants, instruction codes and the execute result record for the
// single-cycle MIPS subset core.
// ----------------------------------------------------------------------------
package mssc_pkg;

  // data memory depth, power of two
  localparam int DATA_WORDS     = 32;
  localparam int REGISTER_COUNT = 32;
  localparam int DW_AW          = $clog2(DATA_WORDS);
  localparam int RF_AW          = $clog2(REGISTER_COUNT);

  localparam logic [1:0] FUNC_EXEC        = 2'd0;
  localparam logic [1:0] FUNC_PRELOAD_REG = 2'd1;
  localparam logic [1:0] FUNC_PRELOAD_MEM = 2'd2;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_NOR = 6'd39;
  localparam logic [5:0] FN_SLT = 6'd42;

  typedef struct packed {
    logic [31:0]      next_pc;
    logic             reg_write;
    logic [RF_AW-1:0] reg_index;
    logic [31:0]      reg_value;
    logic             is_load;
    logic             mem_write;
    logic [DW_AW-1:0] mem_slot;
    logic [4:0]       mem_word_index;
    logic [31:0]      mem_value;
    logic             branch_taken;
    logic             unsupported;
  } exec_res_t;

endpackage

// ----- src/mssc_regfile.sv -----
// ----------------------------------------------------------------------------
// mssc_regfile
// Register file: one write port, two registered read ports, per-entry valid
// bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module mssc_regfile
  import mssc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [RF_AW-1:0] rd_addr_a,
  input  logic [RF_AW-1:0] rd_addr_b,
  output logic [31:0]      rd_data_a,
  output logic [31:0]      rd_data_b,
  input  logic             wr_en,
  input  logic [RF_AW-1:0] wr_addr,
  input  logic [31:0]      wr_data
);

  logic [31:0]               mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld_r;
  logic [31:0]               raw_a_r;
  logic [31:0]               raw_b_r;
  logic                      vld_a_r;
  logic                      vld_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    raw_a_r <= mem[rd_addr_a];
    raw_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_r[rd_addr_a];
      vld_b_r <= vld_r[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a_r ? raw_a_r : 32'd0;
  assign rd_data_b = vld_b_r ? raw_b_r : 32'd0;

endmodule

// ----- src/mssc_dmem.sv -----
// ----------------------------------------------------------------------------
// mssc_dmem
// Data memory: one write port, one registered read port with enable,
// per-word valid bits so that unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module mssc_dmem
  import mssc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [DW_AW-1:0] rd_addr,
  output logic [31:0]      rd_data,
  input  logic             wr_en,
  input  logic [DW_AW-1:0] wr_addr,
  input  logic [31:0]      wr_data
);

  logic [31:0]           mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] vld_r;
  logic [31:0]           raw_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (rd_en) begin
      rvld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rvld_r ? raw_r : 32'd0;

endmodule

// ----- src/mssc_exec.sv -----
// ----------------------------------------------------------------------------
// mssc_exec
// Decode and execute: ALU, branch and jump targets, load/store address and
// preload handling for one item.
// ----------------------------------------------------------------------------
module mssc_exec
  import mssc_pkg::*;
(
  input  logic [1:0]  func,
  input  logic [31:0] instruction,
  input  logic [4:0]  load_index,
  input  logic [31:0] load_value,
  input  logic [31:0] pc,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output exec_res_t   res
);

  logic [5:0]       opcode;
  logic [5:0]       funct;
  logic [4:0]       rt;
  logic [4:0]       rd;
  logic [31:0]      sext;
  logic [31:0]      pc4;
  logic [31:0]      addr;
  logic [DW_AW-1:0] addr_slot;
  logic [31:0]      lidx_ext;
  logic [31:0]      alu;
  logic             alu_ok;
  logic [31:0]      slot_ext;

  assign opcode    = instruction[31:26];
  assign funct     = instruction[5:0];
  assign rt        = instruction[20:16];
  assign rd        = instruction[15:11];
  assign sext      = {{16{instruction[15]}}, instruction[15:0]};
  assign pc4       = pc + 32'd4;
  assign addr      = op_a + sext;
  assign addr_slot = addr[DW_AW+1:2];
  assign lidx_ext  = 32'(load_index);

  always_comb begin
    alu    = 32'd0;
    alu_ok = 1'b1;
    case (funct)
      FN_ADD:  alu = op_a + op_b;
      FN_SUB:  alu = op_a - op_b;
      FN_AND:  alu = op_a & op_b;
      FN_OR:   alu = op_a | op_b;
      FN_NOR:  alu = ~(op_a | op_b);
      FN_SLT:  alu = {31'd0, $signed(op_a) < $signed(op_b)};
      default: alu_ok = 1'b0;
    endcase
  end

  always_comb begin
    res          = '0;
    res.next_pc  = pc;
    case (func)
      FUNC_EXEC: begin
        res.next_pc = pc4;
        case (opcode)
          OP_RTYPE: begin
            if (!alu_ok) begin
              res.unsupported = 1'b1;
            end else if (rd != 5'd0) begin
              res.reg_write = 1'b1;
              res.reg_index = rd;
              res.reg_value = alu;
            end
          end
          OP_J: begin
            res.next_pc      = {pc4[31:28], instruction[25:0], 2'b00};
            res.branch_taken = 1'b1;
          end
          OP_BEQ: begin
            if (op_a == op_b) begin
              res.next_pc      = pc4 + {sext[29:0], 2'b00};
              res.branch_taken = 1'b1;
            end
          end
          OP_LW: begin
            res.is_load  = 1'b1;
            res.mem_slot = addr_slot;
            if (rt != 5'd0) begin
              res.reg_write = 1'b1;
              res.reg_index = rt;
            end
          end
          OP_SW: begin
            res.mem_write = 1'b1;
            res.mem_slot  = addr_slot;
            res.mem_value = op_b;
          end
          default: res.unsupported = 1'b1;
        endcase
      end
      FUNC_PRELOAD_REG: begin
        if (load_index != 5'd0) begin
          res.reg_write = 1'b1;
          res.reg_index = load_index;
          res.reg_value = load_value;
        end
      end
      FUNC_PRELOAD_MEM: begin
        res.mem_write = 1'b1;
        res.mem_slot  = lidx_ext[DW_AW-1:0];
        res.mem_value = load_value;
      end
      default: res.unsupported = 1'b1;
    endcase
    slot_ext           = 32'(res.mem_slot);
    res.mem_word_index = res.mem_write ? slot_ext[4:0] : 5'd0;
  end

endmodule

// ----- src/mips_subset_single_cycle_core_unit.sv -----
// ----------------------------------------------------------------------------
// mips_subset_single_cycle_core_unit
// MIPS subset core (add, sub, and, or, nor, slt, lw, sw, beq, j) with
// register and data memory preload words.
//
//   channel  | direction | handshake             | payload
//   in_      | input     | in_valid / in_ready   | func, instruction, load_*
//   out_     | output    | out_valid / out_ready | next_pc, writes, flags
//
// One word per cycle sustained while out_ready stays high. An accepted word
// is registered in stage 1, then its result in stage 2. Stage 1 holds the
// word and registered register-file reads (forwarded from pending and
// just-landed write-back); stage 2 holds the result and the registered data
// memory read. Register write-back lands on the clock edge after a word
// enters stage 2. Synchronous reset clears PC, valid bits and pipeline.
// A stalled output holds stage 2; stage 1 fills behind it.
// ----------------------------------------------------------------------------
module mips_subset_single_cycle_core_unit
  import mssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [31:0]        in_instruction,
  input  logic [4:0]         in_load_index,
  input  logic signed [31:0] in_load_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_next_pc,
  output logic               out_reg_write,
  output logic [4:0]         out_reg_index,
  output logic signed [31:0] out_reg_value,
  output logic               out_mem_write,
  output logic [4:0]         out_mem_word_index,
  output logic signed [31:0] out_mem_value,
  output logic               out_branch_taken,
  output logic               out_unsupported
);

  logic             s1_vld_r;
  logic [1:0]       s1_func_r;
  logic [31:0]      s1_instr_r;
  logic [4:0]       s1_lidx_r;
  logic [31:0]      s1_lval_r;
  logic             s2_vld_r;
  exec_res_t        s2_r;
  logic [31:0]      pc_r;
  logic             wb_pend_r;
  logic             lw_en_r;
  logic [RF_AW-1:0] lw_addr_r;
  logic [31:0]      lw_data_r;

  logic             in_fire;
  logic             s1_adv;
  logic [4:0]       ra_a;
  logic [4:0]       ra_b;
  logic [4:0]       s1_rs;
  logic [4:0]       s1_rt;
  logic [31:0]      rf_a;
  logic [31:0]      rf_b;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic [31:0]      dm_rdata;
  logic [31:0]      s2_wval;
  exec_res_t        res;

  assign s1_adv   = s1_vld_r && (!s2_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign s1_rs = s1_instr_r[25:21];
  assign s1_rt = s1_instr_r[20:16];
  assign ra_a  = in_fire ? in_instruction[25:21] : s1_rs;
  assign ra_b  = in_fire ? in_instruction[20:16] : s1_rt;

  assign s2_wval = (s2_r.is_load && s2_r.reg_write) ? dm_rdata : s2_r.reg_value;

  mssc_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr_a (ra_a),
    .rd_addr_b (ra_b),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (wb_pend_r),
    .wr_addr   (s2_r.reg_index),
    .wr_data   (s2_wval)
  );

  // forward pending write-back, then the write that just landed
  always_comb begin
    if (wb_pend_r && s2_r.reg_index == s1_rs) begin
      op_a = s2_wval;
    end else if (lw_en_r && lw_addr_r == s1_rs) begin
      op_a = lw_data_r;
    end else begin
      op_a = rf_a;
    end
    if (wb_pend_r && s2_r.reg_index == s1_rt) begin
      op_b = s2_wval;
    end else if (lw_en_r && lw_addr_r == s1_rt) begin
      op_b = lw_data_r;
    end else begin
      op_b = rf_b;
    end
  end

  mssc_exec u_exec (
    .func        (s1_func_r),
    .instruction (s1_instr_r),
    .load_index  (s1_lidx_r),
    .load_value  (s1_lval_r),
    .pc          (pc_r),
    .op_a        (op_a),
    .op_b        (op_b),
    .res         (res)
  );

  mssc_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_adv),
    .rd_addr (res.mem_slot),
    .rd_data (dm_rdata),
    .wr_en   (s1_adv && res.mem_write),
    .wr_addr (res.mem_slot),
    .wr_data (res.mem_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      pc_r      <= 32'd0;
      wb_pend_r <= 1'b0;
      lw_en_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_r <= 1'b1;
        pc_r     <= res.next_pc;
      end else if (out_ready) begin
        s2_vld_r <= 1'b0;
      end
      wb_pend_r <= s1_adv && res.reg_write;
      lw_en_r   <= wb_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r  <= in_func;
      s1_instr_r <= in_instruction;
      s1_lidx_r  <= in_load_index;
      s1_lval_r  <= $unsigned(in_load_value);
    end
    if (s1_adv) begin
      s2_r <= res;
    end
    lw_addr_r <= s2_r.reg_index;
    lw_data_r <= s2_wval;
  end

  assign out_valid          = s2_vld_r;
  assign out_next_pc        = s2_r.next_pc;
  assign out_reg_write      = s2_r.reg_write;
  assign out_reg_index      = s2_r.reg_index;
  assign out_reg_value      = $signed(s2_wval);
  assign out_mem_write      = s2_r.mem_write;
  assign out_mem_word_index = s2_r.mem_word_index;
  assign out_mem_value      = $signed(s2_r.mem_value);
  assign out_branch_taken   = s2_r.branch_taken;
  assign out_unsupported    = s2_r.unsupported;

  a_wb_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |-> s2_r.reg_index != 5'd0)
    else $error("write-back targets register zero");

  a_wb_after_adv: assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |-> $past(s1_adv))
    else $error("write-back without stage advance");

  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(pc_r))
    else $error("pc moved without stage advance");

  a_unsup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unsupported) |-> (!out_reg_write && !out_mem_write))
    else $error("unsupported word caused a write");

  a_adv_fills_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> s2_vld_r)
    else $error("stage 2 empty after advance");

endmodule
